>>> rtl/idpr_pkg.sv
`default_nettype none

package idpr_pkg;

  // Field widths
  localparam int VAL_W      = 8;
  localparam int OFF_W      = 9;
  localparam int SH_W       = 5;
  localparam int CLAMP_W    = 8;
  localparam int SCALE_W    = 32;
  localparam int RES_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  // Accumulator width default and requantization multiply widths
  localparam int ACC_WIDTH_DEF = 32;
  localparam int MUL_W         = 64;
  localparam int HALF_W        = 32;

  // Post-shift limit and the width that holds it
  localparam int LIM_W   = 12;
  localparam int LIM_MAX = 1024;

  // Register reset values
  localparam logic signed [CLAMP_W-1:0] CLAMP_MIN_RST = -8'sd128;
  localparam logic signed [CLAMP_W-1:0] CLAMP_MAX_RST = 8'sd127;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_A_OFFSET      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_B_OFFSET      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_AMOUNT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUND_ENABLE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_OFFSET = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_MIN     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_MAX     = 3'd6;

  // Partial product select of the shared 32x32 multiplier
  typedef enum logic [1:0] {
    MSEL_LL = 2'd0,
    MSEL_HL = 2'd1,
    MSEL_LH = 2'd2
  } mul_sel_e;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_MUL0  = 8'b0000_0010,
    ST_MUL1  = 8'b0000_0100,
    ST_MUL2  = 8'b0000_1000,
    ST_SUM   = 8'b0001_0000,
    ST_ADD   = 8'b0010_0000,
    ST_SHIFT = 8'b0100_0000,
    ST_WRITE = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic     mac;
    logic     load_op;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     p_init;
    logic     p_acc;
    logic     add_en;
    logic     shift_en;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_last;
    logic out_ready;
  } stat_t;

endpackage

`default_nettype wire

>>> rtl/idpr_in_if.sv
`default_nettype none

interface idpr_in_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [idpr_pkg::VAL_W-1:0]         a_val;
  logic signed [idpr_pkg::VAL_W-1:0]         b_val;
  logic signed [idpr_pkg::SCALE_W-1:0]       scale_mul;
  logic signed [idpr_pkg::SCALE_W-1:0]       scale_add;
  logic                                      last;

  modport source (output valid, a_val, b_val, scale_mul, scale_add, last, input ready);
  modport sink   (input valid, a_val, b_val, scale_mul, scale_add, last, output ready);
endinterface

`default_nettype wire

>>> rtl/idpr_out_if.sv
`default_nettype none

interface idpr_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [idpr_pkg::RES_W-1:0] result;

  modport source (output valid, result, input ready);
  modport sink   (input valid, result, output ready);
endinterface

`default_nettype wire

>>> rtl/int8_dot_product_requantize.sv
`default_nettype none

// Channel  | Dir | Payload                                        | Transfer
// ---------+-----+------------------------------------------------+---------------------
// in_i     | in  | a_val, b_val, scale_mul, scale_add, last       | valid & ready
// out_o    | out | result                                         | valid & ready
// cfg      | in  | cfg_we_i, cfg_idx_i, cfg_data_i                | cfg_we_i high
//
// An item without last: the MAC adds the offset pair product into the accumulator and
// the block is ready again in the next cycle.
// An item with last passes the MAC step, three partial products through the shared
// 32x32 multiplier and their sum, then bias add, shift and clamp, before the next item
// is taken.
// Reset clears the accumulator and the registers to their reset values.
// The output register holds a finished result while items keep streaming in; a result
// stalled there holds only the next last item at its final clamp step.

module int8_dot_product_requantize #(
  parameter int ACC_WIDTH = idpr_pkg::ACC_WIDTH_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  idpr_in_if.sink                              in_i,
  idpr_out_if.source                           out_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [idpr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [idpr_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  idpr_pkg::cmd_t  cmd;
  idpr_pkg::stat_t stat;

  // gather handshake status for the controller
  assign stat.in_valid  = in_i.valid;
  assign stat.in_last   = in_i.last;
  assign stat.out_ready = out_o.ready;

  idpr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid)
  );

  idpr_dp #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .a_val_i     (in_i.a_val),
    .b_val_i     (in_i.b_val),
    .scale_mul_i (in_i.scale_mul),
    .scale_add_i (in_i.scale_add),
    .result_o    (out_o.result)
  );

endmodule

`default_nettype wire

>>> rtl/idpr_ctrl.sv
`default_nettype none

module idpr_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  idpr_pkg::stat_t     stat_i,
  output idpr_pkg::cmd_t      cmd_o,
  output logic                in_ready_o,
  output logic                out_valid_o
);

  idpr_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             accept;
  logic             slot_free;

  assign in_ready_o  = (state_q == idpr_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_ready_o & stat_i.in_valid;
  assign slot_free   = ~out_valid_q | stat_i.out_ready;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.mul_sel  = idpr_pkg::MSEL_LL;
    unique case (state_q)
      idpr_pkg::ST_IDLE: begin
        cmd_o.mac     = accept;
        cmd_o.load_op = accept & stat_i.in_last;
        if (accept && stat_i.in_last) state_d = idpr_pkg::ST_MUL0;
      end
      idpr_pkg::ST_MUL0: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = idpr_pkg::MSEL_LL;
        state_d       = idpr_pkg::ST_MUL1;
      end
      idpr_pkg::ST_MUL1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = idpr_pkg::MSEL_HL;
        cmd_o.p_init  = 1'b1;
        state_d       = idpr_pkg::ST_MUL2;
      end
      idpr_pkg::ST_MUL2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = idpr_pkg::MSEL_LH;
        cmd_o.p_acc   = 1'b1;
        state_d       = idpr_pkg::ST_SUM;
      end
      idpr_pkg::ST_SUM: begin
        cmd_o.p_acc = 1'b1;
        state_d     = idpr_pkg::ST_ADD;
      end
      idpr_pkg::ST_ADD: begin
        cmd_o.add_en = 1'b1;
        state_d      = idpr_pkg::ST_SHIFT;
      end
      idpr_pkg::ST_SHIFT: begin
        cmd_o.shift_en = 1'b1;
        state_d        = idpr_pkg::ST_WRITE;
      end
      idpr_pkg::ST_WRITE: begin
        // hold until the output register is free or being drained
        cmd_o.out_load = slot_free;
        if (slot_free) state_d = idpr_pkg::ST_IDLE;
      end
      default: state_d = idpr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q & ~stat_i.out_ready;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= idpr_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/idpr_dp.sv
`default_nettype none

module idpr_dp #(
  parameter int ACC_WIDTH = idpr_pkg::ACC_WIDTH_DEF
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  idpr_pkg::cmd_t                               cmd_i,
  input  wire logic                                    cfg_we_i,
  input  wire logic [idpr_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  wire logic [idpr_pkg::CFG_DATA_W-1:0]         cfg_data_i,
  input  wire logic signed [idpr_pkg::VAL_W-1:0]       a_val_i,
  input  wire logic signed [idpr_pkg::VAL_W-1:0]       b_val_i,
  input  wire logic signed [idpr_pkg::SCALE_W-1:0]     scale_mul_i,
  input  wire logic signed [idpr_pkg::SCALE_W-1:0]     scale_add_i,
  output logic signed [idpr_pkg::RES_W-1:0]            result_o
);

  localparam int MulW  = idpr_pkg::MUL_W;
  localparam int HalfW = idpr_pkg::HALF_W;
  localparam int LimW  = idpr_pkg::LIM_W;
  localparam int SumW  = LimW + 1;
  localparam int OpW   = idpr_pkg::OFF_W + 1;
  localparam int ProdW = 2 * OpW;

  // configuration registers
  logic signed [idpr_pkg::OFF_W-1:0]   a_off_q, b_off_q, out_off_q;
  logic        [idpr_pkg::SH_W-1:0]    shift_q;
  logic                                round_q;
  logic signed [idpr_pkg::CLAMP_W-1:0] cmin_q, cmax_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_off_q   <= '0;
      b_off_q   <= '0;
      shift_q   <= '0;
      round_q   <= 1'b0;
      out_off_q <= '0;
      cmin_q    <= idpr_pkg::CLAMP_MIN_RST;
      cmax_q    <= idpr_pkg::CLAMP_MAX_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        idpr_pkg::CFG_A_OFFSET:      a_off_q   <= cfg_data_i;
        idpr_pkg::CFG_B_OFFSET:      b_off_q   <= cfg_data_i;
        idpr_pkg::CFG_SHIFT_AMOUNT:  shift_q   <= cfg_data_i[idpr_pkg::SH_W-1:0];
        idpr_pkg::CFG_ROUND_ENABLE:  round_q   <= cfg_data_i[0];
        idpr_pkg::CFG_OUTPUT_OFFSET: out_off_q <= cfg_data_i;
        idpr_pkg::CFG_CLAMP_MIN:     cmin_q    <= cfg_data_i[idpr_pkg::CLAMP_W-1:0];
        idpr_pkg::CFG_CLAMP_MAX:     cmax_q    <= cfg_data_i[idpr_pkg::CLAMP_W-1:0];
        default: ;
      endcase
    end
  end

  // multiply-accumulate
  logic signed [OpW-1:0]   a_sum, b_sum;
  logic signed [ProdW-1:0] prod;
  logic [ACC_WIDTH-1:0]    acc_q, acc_sum;

  assign a_sum   = OpW'(a_val_i) + OpW'(a_off_q);
  assign b_sum   = OpW'(b_val_i) + OpW'(b_off_q);
  assign prod    = a_sum * b_sum;
  assign acc_sum = acc_q + ACC_WIDTH'(prod);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (cmd_i.load_op) begin
      acc_q <= '0;
    end else if (cmd_i.mac) begin
      acc_q <= acc_sum;
    end
  end

  // requantization operands, latched with the last item
  logic [ACC_WIDTH-1:0]              opa_q;
  logic signed [idpr_pkg::SCALE_W-1:0] smul_q, sadd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_op) begin
      opa_q  <= acc_sum;
      smul_q <= scale_mul_i;
      sadd_q <= scale_add_i;
    end
  end

  // low half of a 64-bit product from three 32x32 partial products
  logic [MulW-1:0]  opa_ext, smul_ext;
  logic [HalfW-1:0] mul_a, mul_b;
  logic [MulW-1:0]  m_q, p_q;

  assign opa_ext  = MulW'($signed(opa_q));
  assign smul_ext = MulW'(smul_q);

  always_comb begin
    case (cmd_i.mul_sel)
      idpr_pkg::MSEL_HL: begin
        mul_a = opa_ext[MulW-1:HalfW];
        mul_b = smul_ext[HalfW-1:0];
      end
      idpr_pkg::MSEL_LH: begin
        mul_a = opa_ext[HalfW-1:0];
        mul_b = smul_ext[MulW-1:HalfW];
      end
      default: begin
        mul_a = opa_ext[HalfW-1:0];
        mul_b = smul_ext[HalfW-1:0];
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) m_q <= MulW'(mul_a) * MulW'(mul_b);
    if (cmd_i.p_init) begin
      p_q <= m_q;
    end else if (cmd_i.p_acc) begin
      p_q <= p_q + {m_q[HalfW-1:0], {HalfW{1'b0}}};
    end
  end

  // add rounding bias and row term, wrapping at the accumulator width
  logic [MulW-1:0]      bias;
  logic [ACC_WIDTH-1:0] t_q;
  logic [idpr_pkg::SH_W-1:0] sh_m1;

  assign sh_m1 = shift_q - idpr_pkg::SH_W'(1);
  assign bias  = (round_q && (shift_q != '0)) ? (MulW'(1) << sh_m1) : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_en) begin
      t_q <= p_q[ACC_WIDTH-1:0] + bias[ACC_WIDTH-1:0] + ACC_WIDTH'(MulW'(sadd_q));
    end
  end

  // arithmetic shift, then limit to a range that cannot change the clamp
  logic signed [ACC_WIDTH-1:0] u;
  logic signed [LimW-1:0]      lim_q, lim_d;

  assign u = $signed(t_q) >>> shift_q;

  always_comb begin
    if (u < -ACC_WIDTH'(idpr_pkg::LIM_MAX)) begin
      lim_d = -LimW'(idpr_pkg::LIM_MAX);
    end else if (u > ACC_WIDTH'(idpr_pkg::LIM_MAX)) begin
      lim_d = LimW'(idpr_pkg::LIM_MAX);
    end else begin
      lim_d = LimW'(u);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift_en) lim_q <= lim_d;
  end

  // output offset and clamp; a low violation wins over crossed bounds
  logic signed [SumW-1:0] r, lo, hi, cl;

  assign r  = SumW'(lim_q) + SumW'(out_off_q);
  assign lo = SumW'(cmin_q);
  assign hi = SumW'(cmax_q);

  always_comb begin
    if (r < lo) begin
      cl = lo;
    end else if (r > hi) begin
      cl = hi;
    end else begin
      cl = r;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) result_o <= cl[idpr_pkg::RES_W-1:0];
  end

endmodule

`default_nettype wire
